// ===== hw/rtl/tcgr_pkg.sv =====
// shared types and constants for the text cell glyph renderer
// no dependencies; imported by every module of the block except tcgr_ram
package tcgr_pkg;

    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int GLYPH_COUNT_DEF = 256;

    localparam int          CELL_W    = 8;
    localparam int          ROW_MAX   = 4095;
    localparam logic [7:0]  FULL_MASK = 8'hFF;

    localparam logic [31:0] FG_RESET    = 32'hFFFF_FFFF;
    localparam logic [31:0] BG_RESET    = 32'h0000_0000;
    localparam logic [12:0] WIDTH_RESET = 13'd1024;
    localparam logic [12:0] PITCH_RESET = 13'd1024;

    typedef enum logic [2:0] {
        OP_DRAW       = 3'd0,
        OP_BACKSPACE  = 3'd1,
        OP_NEWLINE    = 3'd2,
        OP_SET_CURSOR = 3'd3,
        OP_LOAD_ROW   = 3'd4
    } op_e;

    typedef enum logic [1:0] {
        CFG_FOREGROUND = 2'd0,
        CFG_CLEAR      = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_PITCH      = 2'd3
    } cfg_reg_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } state_e;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  char_code;
        logic [12:0] new_cursor_x;
        logic [11:0] new_cursor_y;
        logic [3:0]  glyph_row_index;
        logic [7:0]  glyph_row_bits;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_word_offset;
        logic [7:0]  row_pixel_mask;
        logic [31:0] pixel_colour;
        logic        last_row;
    } out_item_t;

    // side information that travels alongside one font read
    typedef struct packed {
        logic [23:0] offset;
        logic [31:0] colour;
        logic        last;
        logic        from_font;
        logic        font_hit;
    } row_tag_t;

endpackage

// ===== hw/rtl/text_cell_glyph_renderer_top.sv =====
// text console renderer: cursor, 8-pixel-wide bitmap font in ram, row write stream
// depends on tcgr_pkg, tcgr_ram, tcgr_ctrl and tcgr_out
//
// Input channel (in_valid/in_ready/in_item) takes one operation per transaction:
// draw char, backspace, newline, set cursor or load one font row. Draw and
// backspace each produce GLYPH_ROWS row writes on the output channel
// (out_valid/out_ready/out_item), top row first, last_row set on the final one.
// Other operations finish in the cycle they are taken and produce nothing.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and cfg_data
// and are applied at once; cfg_ready is always high. Write them only when idle.
// The first row write of a cell passes the setup state, the font read and row tag
// registers and the output queue before it is valid. A cell keeps the input closed
// while it is taken, while the row address is formed, and then while one font ram
// read per row runs through the ram's single read port; the next cell waits for it.
// A stalled receiver holds out_valid; a two-entry output queue keeps reads
// running until it fills, then reads pause until rows drain.
// Reset clears the cursor to column 0, row 0 and restores the register defaults;
// font ram contents are undefined until rows are loaded.
module text_cell_glyph_renderer_top #(
    parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcgr_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output tcgr_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    import tcgr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          tag_valid;
    row_tag_t      tag;
    logic          space;

    tcgr_ctrl #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .tag_valid (tag_valid),
        .tag       (tag),
        .space     (space)
    );

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcgr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_valid (tag_valid),
        .tag       (tag),
        .rdata     (ram_rdata),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // a font read is only started when the output queue can take its row
    a_read_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> space)
        else $error("font read issued without output queue room");

    // a cell transaction keeps the input closed on the next cycle
    a_cell_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready
         && (in_item.operation == OP_DRAW || in_item.operation == OP_BACKSPACE))
        |=> !in_ready)
        else $error("input reopened during a cell");

    // the last row read of a cell returns the sequencer to idle
    a_last_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_valid && tag.last) |-> in_ready)
        else $error("sequencer not idle after last row read");

    // no font ram read and write collide in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("font ram read and write in the same cycle");

endmodule

// ===== hw/rtl/tcgr_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tcgr_ctrl.sv =====
// cursor, configuration registers and the sequencer that walks one cell's font rows
// depends on tcgr_pkg; drives the font ram and the row tags toward tcgr_out
module tcgr_ctrl #(
    parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF,
    localparam int AW         = $clog2(GLYPH_COUNT * GLYPH_ROWS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcgr_pkg::in_item_t  in_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output logic [7:0]          ram_wdata,
    output logic                ram_re,
    output logic [AW-1:0]       ram_raddr,
    output logic                tag_valid,
    output tcgr_pkg::row_tag_t  tag,
    input  logic                space
);

    import tcgr_pkg::*;

    localparam int RCW = $clog2(GLYPH_ROWS);

    state_e      state_reg, state_next;
    logic [31:0] fg_reg, fg_next;
    logic [31:0] bg_reg, bg_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] pitch_reg, pitch_next;
    logic [12:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [12:0] cell_x_reg, cell_x_next;
    logic [11:0] cell_row_reg, cell_row_next;
    logic        is_draw_reg, is_draw_next;
    logic        font_hit_reg, font_hit_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic [23:0] off_reg, off_next;
    logic        tag_valid_reg, tag_valid_next;
    row_tag_t    tag_reg, tag_next;

    logic        code_ok;
    logic        idx_ok;
    logic [12:0] col_adv;
    logic        wrap;
    logic [12:0] bs_col;
    logic [11:0] bs_row;
    logic [12:0] bs_x;
    logic [24:0] mult;
    logic        last;

    function automatic logic [11:0] row_down(input logic [11:0] r);
        logic [12:0] n;
        n = {1'b0, r} + 13'(GLYPH_ROWS);
        return (n > 13'(ROW_MAX)) ? 12'(ROW_MAX) : n[11:0];
    endfunction

    function automatic logic [11:0] row_up(input logic [11:0] r);
        return (r < 12'(GLYPH_ROWS)) ? 12'd0 : r - 12'(GLYPH_ROWS);
    endfunction

    assign code_ok = {24'b0, in_item.char_code} < 32'(GLYPH_COUNT);
    assign idx_ok  = {28'b0, in_item.glyph_row_index} < 32'(GLYPH_ROWS);

    // draw: advance, wrap when the following cell would pass the width
    assign col_adv = col_reg + 13'(CELL_W);
    assign wrap    = ({1'b0, col_adv} + 14'(CELL_W)) > {1'b0, width_reg};

    // backspace at column zero first steps to the end of the line above
    assign bs_col = (col_reg == 13'd0) ? width_reg : col_reg;
    assign bs_row = (col_reg == 13'd0) ? row_up(row_reg) : row_reg;
    assign bs_x   = (bs_col >= 13'(CELL_W)) ? bs_col - 13'(CELL_W) : 13'd0;

    assign mult = {13'b0, cell_row_reg} * {12'b0, pitch_reg};
    assign last = rcnt_reg == RCW'(GLYPH_ROWS - 1);

    assign in_ready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign ram_raddr = addr_reg;
    assign tag_valid = tag_valid_reg;
    assign tag       = tag_reg;

    always_comb
    begin
        state_next     = state_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        width_next     = width_reg;
        pitch_next     = pitch_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cell_x_next    = cell_x_reg;
        cell_row_next  = cell_row_reg;
        is_draw_next   = is_draw_reg;
        font_hit_next  = font_hit_reg;
        addr_next      = addr_reg;
        rcnt_next      = rcnt_reg;
        off_next       = off_reg;
        tag_valid_next = 1'b0;
        tag_next       = tag_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'({24'b0, in_item.char_code} * 32'(GLYPH_ROWS)
                             + {28'b0, in_item.glyph_row_index});
        ram_wdata      = in_item.glyph_row_bits;
        ram_re         = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FOREGROUND: fg_next    = cfg_data;
                CFG_CLEAR:      bg_next    = cfg_data;
                CFG_WIDTH:      width_next = cfg_data[12:0];
                CFG_PITCH:      pitch_next = cfg_data[12:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.operation)
                        OP_DRAW:
                        begin
                            cell_x_next   = col_reg;
                            cell_row_next = row_reg;
                            is_draw_next  = 1'b1;
                            font_hit_next = code_ok;
                            addr_next     = AW'({24'b0, in_item.char_code}
                                                * 32'(GLYPH_ROWS));
                            if (wrap)
                            begin
                                col_next = 13'd0;
                                row_next = row_down(row_reg);
                            end
                            else
                            begin
                                col_next = col_adv;
                            end
                            state_next = ST_SETUP;
                        end
                        OP_BACKSPACE:
                        begin
                            cell_x_next   = bs_x;
                            cell_row_next = bs_row;
                            is_draw_next  = 1'b0;
                            font_hit_next = 1'b0;
                            if (bs_col < 13'(CELL_W))
                            begin
                                col_next = width_reg;
                                row_next = row_up(bs_row);
                            end
                            else
                            begin
                                col_next = bs_col - 13'(CELL_W);
                                row_next = bs_row;
                            end
                            state_next = ST_SETUP;
                        end
                        OP_NEWLINE:
                        begin
                            col_next = 13'd0;
                            row_next = row_down(row_reg);
                        end
                        OP_SET_CURSOR:
                        begin
                            col_next = in_item.new_cursor_x;
                            row_next = in_item.new_cursor_y;
                        end
                        OP_LOAD_ROW:
                        begin
                            ram_we = code_ok && idx_ok;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETUP:
            begin
                off_next   = mult[23:0] + {11'b0, cell_x_reg};
                rcnt_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // one font row per cycle while the output queue has room
                if (space)
                begin
                    ram_re             = 1'b1;
                    tag_valid_next     = 1'b1;
                    tag_next.offset    = off_reg;
                    tag_next.colour    = is_draw_reg ? fg_reg : bg_reg;
                    tag_next.last      = last;
                    tag_next.from_font = is_draw_reg;
                    tag_next.font_hit  = font_hit_reg;
                    off_next           = off_reg + {11'b0, pitch_reg};
                    addr_next          = addr_reg + AW'(1);
                    rcnt_next          = rcnt_reg + RCW'(1);
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            width_reg     <= WIDTH_RESET;
            pitch_reg     <= PITCH_RESET;
            col_reg       <= 13'd0;
            row_reg       <= 12'd0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            width_reg     <= width_next;
            pitch_reg     <= pitch_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tag_valid_reg <= tag_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_x_reg   <= cell_x_next;
        cell_row_reg <= cell_row_next;
        is_draw_reg  <= is_draw_next;
        font_hit_reg <= font_hit_next;
        addr_reg     <= addr_next;
        rcnt_reg     <= rcnt_next;
        off_reg      <= off_next;
        tag_reg      <= tag_next;
    end

endmodule

// ===== hw/rtl/tcgr_out.sv =====
// output stage: merges font read data with its row tag into a two-entry queue
// depends on tcgr_pkg; grants read credit back to tcgr_ctrl
module tcgr_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tag_valid,
    input  tcgr_pkg::row_tag_t  tag,
    input  logic [7:0]          rdata,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output tcgr_pkg::out_item_t out_item
);

    import tcgr_pkg::*;

    out_item_t   ent_reg [2];
    out_item_t   row_item;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;
    logic [2:0]  occ;

    always_comb
    begin
        row_item.pixel_word_offset = tag.offset;
        row_item.pixel_colour      = tag.colour;
        row_item.last_row          = tag.last;
        if (tag.from_font)
        begin
            row_item.row_pixel_mask = tag.font_hit ? rdata : 8'h00;
        end
        else
        begin
            row_item.row_pixel_mask = FULL_MASK;
        end
    end

    assign out_valid = count_reg != 2'd0;
    assign out_item  = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // entries held plus the read in flight, after this cycle's transaction
    assign occ   = {1'b0, count_reg} + {2'b0, tag_valid};
    assign space = (occ - {2'b0, pop}) < 3'd2;

    always_comb
    begin
        wr_ptr_next = tag_valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, tag_valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_valid)
        begin
            ent_reg[wr_ptr_reg] <= row_item;
        end
    end

endmodule

// ===== tb/glyph_row_checker.sv =====
// row write checker for the text cell glyph renderer: tracks cursor, font and registers,
// predicts the row writes of every operation and compares them with the output stream
// depends on tcgr_pkg
module glyph_row_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  tcgr_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_ready,
    input  tcgr_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  mismatches,
    output int                  rows_outstanding
);

    import tcgr_pkg::*;

    localparam int GLYPH_ROWS  = GLYPH_ROWS_DEF;
    localparam int FONT_DEPTH  = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF;

    logic [31:0] fg_colour;
    logic [31:0] bg_colour;
    logic [12:0] screen_width;
    logic [12:0] pitch;
    logic [12:0] cur_col;
    logic [11:0] cur_row;
    logic [7:0]  font_rows [FONT_DEPTH];
    out_item_t   pending_row_writes [$];
    out_item_t   want;
    int          mismatch_count = 0;

    task automatic report_mismatch(input string what, input longint expected_value,
                                   input longint got_value);
        $display("%0t mismatch %s: expected %0h, got %0h", $time, what,
                 expected_value, got_value);
        mismatch_count++;
    endtask

    function automatic logic [11:0] line_below(input logic [11:0] y);
        int n;
        n = int'(y) + GLYPH_ROWS;
        return (n > ROW_MAX) ? 12'(ROW_MAX) : 12'(n);
    endfunction

    function automatic logic [11:0] line_above(input logic [11:0] y);
        return (int'(y) < GLYPH_ROWS) ? 12'd0 : 12'(int'(y) - GLYPH_ROWS);
    endfunction

    task automatic queue_row_write(input int r, input logic [12:0] x, input logic [7:0] mask,
                                   input logic [31:0] colour);
        out_item_t w;
        longint    offset;
        offset = (longint'(cur_row) + r) * longint'(pitch) + longint'(x);
        w.pixel_word_offset = offset[23:0];
        w.row_pixel_mask    = mask;
        w.pixel_colour      = colour;
        w.last_row          = (r == GLYPH_ROWS - 1);
        pending_row_writes.push_back(w);
    endtask

    task automatic render_operation(input in_item_t item);
        logic [12:0] erase_x;
        case (item.operation)
            OP_DRAW:
            begin
                for (int r = 0; r < GLYPH_ROWS; r++)
                    queue_row_write(r, cur_col,
                                    font_rows[int'(item.char_code) * GLYPH_ROWS + r], fg_colour);
                cur_col = cur_col + 13'(CELL_W);
                if (int'(cur_col) + CELL_W > int'(screen_width))
                begin
                    cur_col = '0;
                    cur_row = line_below(cur_row);
                end
            end
            OP_BACKSPACE:
            begin
                // at column 0 the cursor first moves to the end of the line above
                if (cur_col == '0)
                begin
                    cur_col = screen_width;
                    cur_row = line_above(cur_row);
                end
                erase_x = (int'(cur_col) >= CELL_W) ? 13'(int'(cur_col) - CELL_W) : '0;
                for (int r = 0; r < GLYPH_ROWS; r++)
                    queue_row_write(r, erase_x, FULL_MASK, bg_colour);
                if (int'(cur_col) < CELL_W)
                begin
                    cur_col = screen_width;
                    cur_row = line_above(cur_row);
                end
                else
                    cur_col = 13'(int'(cur_col) - CELL_W);
            end
            OP_NEWLINE:
            begin
                cur_col = '0;
                cur_row = line_below(cur_row);
            end
            OP_SET_CURSOR:
            begin
                cur_col = item.new_cursor_x;
                cur_row = item.new_cursor_y;
            end
            OP_LOAD_ROW:
            begin
                if (int'(item.glyph_row_index) < GLYPH_ROWS &&
                    int'(item.char_code) < GLYPH_COUNT_DEF)
                    font_rows[int'(item.char_code) * GLYPH_ROWS + int'(item.glyph_row_index)] =
                        item.glyph_row_bits;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_colour    = FG_RESET;
            bg_colour    = BG_RESET;
            screen_width = WIDTH_RESET;
            pitch        = PITCH_RESET;
            cur_col      = '0;
            cur_row      = '0;
            pending_row_writes.delete();
        end
        else
        begin
            // outputs first: a row write never belongs to the transaction taken at this edge
            if (out_valid && out_ready)
            begin
                if (pending_row_writes.size() == 0)
                    report_mismatch("row write with nothing expected", 0,
                                    out_item.pixel_word_offset);
                else
                begin
                    want = pending_row_writes.pop_front();
                    if (out_item.pixel_word_offset !== want.pixel_word_offset)
                        report_mismatch("pixel_word_offset", want.pixel_word_offset,
                                        out_item.pixel_word_offset);
                    if (out_item.row_pixel_mask !== want.row_pixel_mask)
                        report_mismatch("row_pixel_mask", want.row_pixel_mask,
                                        out_item.row_pixel_mask);
                    if (out_item.pixel_colour !== want.pixel_colour)
                        report_mismatch("pixel_colour", want.pixel_colour,
                                        out_item.pixel_colour);
                    if (out_item.last_row !== want.last_row)
                        report_mismatch("last_row", want.last_row, out_item.last_row);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOREGROUND: fg_colour    = cfg_data;
                    CFG_CLEAR:      bg_colour    = cfg_data;
                    CFG_WIDTH:      screen_width = cfg_data[12:0];
                    CFG_PITCH:      pitch        = cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                render_operation(in_item);
        end
        mismatches       <= mismatch_count;
        rows_outstanding <= pending_row_writes.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the text cell glyph renderer bench: clock, reset, stimulus, receiver and verdict
// depends on tcgr_pkg, text_cell_glyph_renderer_top and glyph_row_checker
module testbench;
    import tcgr_pkg::*;

    localparam int          ROWS_PER_GLYPH  = GLYPH_ROWS_DEF;
    localparam int          RANDOM_PHASES   = 4;
    localparam int          ITEMS_PER_PHASE = 52;
    localparam int          BURST_DRAWS     = 16;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          DRAIN_CYCLES    = 30;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int          mismatches;
    int          rows_outstanding;
    int          quiet_cycles  = 0;
    bit          sender_gaps   = 1'b1;
    bit          burst_started = 1'b0;
    int          screen_w      = WIDTH_RESET;

    // glyphs whose rows have all been loaded, and the glyph currently being filled in
    logic [7:0]  drawable_glyphs [$];
    int          glyph_in_progress = 1;
    int          row_in_progress   = 0;

    text_cell_glyph_renderer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glyph_row_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .rows_outstanding (rows_outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int random_extent();
        case ($urandom_range(0, 4))
            0: return 8;
            1: return 4096;
            2: return 8 * $urandom_range(1, 512);
            default: return $urandom_range(8, 4096);
        endcase
    endfunction

    function automatic in_item_t noise_item();
        in_item_t n;
        n.operation       = 3'($urandom);
        n.char_code       = 8'($urandom);
        n.new_cursor_x    = 13'($urandom_range(0, 4096));
        n.new_cursor_y    = 12'($urandom);
        n.glyph_row_index = 4'($urandom);
        n.glyph_row_bits  = 8'($urandom);
        return n;
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [2:0] op);
        in_item_t item;
        item = noise_item();
        item.operation = op;
        send_item(item);
    endtask

    task automatic send_draw(input logic [7:0] code);
        in_item_t item;
        item = noise_item();
        item.operation = OP_DRAW;
        item.char_code = code;
        send_item(item);
    endtask

    task automatic send_cursor(input int x, input int y);
        in_item_t item;
        item = noise_item();
        item.operation    = OP_SET_CURSOR;
        item.new_cursor_x = 13'(x);
        item.new_cursor_y = 12'(y);
        send_item(item);
    endtask

    task automatic send_load(input logic [7:0] code, input int row, input logic [7:0] bits);
        in_item_t item;
        item = noise_item();
        item.operation       = OP_LOAD_ROW;
        item.char_code       = code;
        item.glyph_row_index = 4'(row);
        item.glyph_row_bits  = bits;
        send_item(item);
    endtask

    // stop offering items and let every outstanding row write and the pipeline drain
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (rows_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] fg, input logic [31:0] clear,
                                  input int width, input int pitch);
        logic [31:0] values [4];
        values[CFG_FOREGROUND] = fg;
        values[CFG_CLEAR]      = clear;
        values[CFG_WIDTH]      = 32'(width);
        values[CFG_PITCH]      = 32'(pitch);
        screen_w = width;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= cfg_reg_e'(i);
            cfg_data  <= values[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic load_glyph(input logic [7:0] code);
        logic [7:0] bits;
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
        begin
            case (r)
                0: bits = 8'h00;
                1: bits = 8'hFF;
                2: bits = 8'h80;
                3: bits = 8'h01;
                default: bits = 8'($urandom);
            endcase
            send_load(code, r, bits);
        end
        drawable_glyphs.push_back(code);
    endtask

    task automatic pick_random_operation(output in_item_t item);
        int roll;
        int x;
        roll = $urandom_range(0, 99);
        item = noise_item();
        if (roll < 42)
        begin
            item.operation = OP_DRAW;
            item.char_code = drawable_glyphs[$urandom_range(0, drawable_glyphs.size() - 1)];
        end
        else if (roll < 56)
            item.operation = OP_BACKSPACE;
        else if (roll < 63)
            item.operation = OP_NEWLINE;
        else if (roll < 75)
        begin
            item.operation = OP_SET_CURSOR;
            case ($urandom_range(0, 3))
                0: x = $urandom_range(0, 4096);
                1: x = screen_w - $urandom_range(0, 8);
                2: x = $urandom_range(0, 7);
                default: x = 8 * $urandom_range(0, screen_w / 8);
            endcase
            item.new_cursor_x = 13'(x);
            case ($urandom_range(0, 3))
                0: item.new_cursor_y = 12'($urandom_range(4064, 4095));
                1: item.new_cursor_y = 12'($urandom_range(0, 40));
                default: item.new_cursor_y = 12'($urandom_range(0, 4095));
            endcase
        end
        else if (roll < 95)
        begin
            item.operation = OP_LOAD_ROW;
            if ($urandom_range(0, 9) == 0)
                item.glyph_row_bits = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            if (glyph_in_progress < 255 && $urandom_range(0, 1) == 0)
            begin
                item.char_code       = 8'(glyph_in_progress);
                item.glyph_row_index = 4'(row_in_progress);
                row_in_progress++;
                if (row_in_progress == ROWS_PER_GLYPH)
                begin
                    drawable_glyphs.push_back(8'(glyph_in_progress));
                    glyph_in_progress++;
                    row_in_progress = 0;
                end
            end
            else
                item.char_code = drawable_glyphs[$urandom_range(0, drawable_glyphs.size() - 1)];
        end
        else
            item.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    endtask

    initial
    begin : receiver
        int  run_len;
        int  gap;
        bit  held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // one long hold-off while the sender keeps pushing draws
            if (burst_started && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
            repeat (run_len) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        in_item_t item;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(32'h0000_0000, 32'hFFFF_FFFF, 4096, 4096);
        load_glyph(8'h00);
        load_glyph(8'hFF);

        send_draw(8'h00);
        send_draw(8'hFF);
        send_cursor(4088, 0);       // right edge: next cell would pass the width
        send_draw(8'hFF);
        send_cursor(4096, 4095);    // offset wraps and the row saturates
        send_draw(8'h00);
        send_cursor(0, 0);          // backspace at the top-left corner clamps
        send_op(OP_BACKSPACE);
        send_cursor(3, 40);         // column below one cell width
        send_op(OP_BACKSPACE);
        send_op(OP_BACKSPACE);
        send_cursor(100, 4090);
        send_op(OP_NEWLINE);
        send_op(OP_NEWLINE);
        send_op(OP_FIRST_UNUSED);
        send_op(3'(OP_FIRST_UNUSED + 1));
        send_op(OP_LAST_UNUSED);
        send_draw(8'h00);

        wait_drained();
        apply_settings($urandom, $urandom, 8, 8);
        send_draw(8'hFF);
        send_draw(8'h00);
        send_op(OP_BACKSPACE);
        send_op(OP_BACKSPACE);
        send_op(OP_NEWLINE);
        send_op(OP_BACKSPACE);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase == RANDOM_PHASES - 1)
                apply_settings(FG_RESET, BG_RESET, WIDTH_RESET, PITCH_RESET);
            else
                apply_settings($urandom, $urandom, random_extent(), random_extent());
            sender_gaps = (phase != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == 20)
                begin
                    burst_started = 1'b1;
                    sender_gaps   = 1'b0;
                    for (int b = 0; b < BURST_DRAWS; b++)
                        send_draw(drawable_glyphs[$urandom_range(0, drawable_glyphs.size() - 1)]);
                    sender_gaps = 1'b1;
                end
                pick_random_operation(item);
                send_item(item);
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
